// ----- rtl/lcg_random_generator_unit_assert.svh -----
// assertion macros shared by the lcg checker
`ifndef LCG_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define LCG_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCG_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lcg port check failed");

// next-cycle implication, disabled during reset
`define LCG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lcg port check failed");

`endif

// ----- rtl/lcg_pkg.sv -----
// package for the lcg random generator: widths, register map and reset values
`timescale 1ns / 1ps

package lcg_pkg;

   // generator word width default
   localparam int unsigned DefaultWidth = 48;

   // request field widths and run limit
   localparam int unsigned CountWidth = 7;
   localparam int unsigned MaxRun     = 64;

   // configuration port geometry
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned RegIdxWidth  = 2;

   // register indexes
   localparam logic [RegIdxWidth-1:0] RegMultiplier = 2'd0;
   localparam logic [RegIdxWidth-1:0] RegIncrement  = 2'd1;
   localparam logic [RegIdxWidth-1:0] RegModulus    = 2'd2;
   localparam logic [RegIdxWidth-1:0] RegSeed       = 2'd3;

   // register reset values
   localparam int unsigned MultiplierReset = 3;
   localparam int unsigned IncrementReset  = 6;
   localparam int unsigned ModulusReset    = 10;
   localparam int unsigned SeedReset       = 4;

endpackage

// ----- rtl/lcg_random_generator_unit.sv -----
// Linear congruential generator: X = (a*X + c) mod m, with a shared modular
// add/compare unit. A request word (reseed, count) yields count result words,
// count saturating at 64; the last word of the run has rsp_last set. A count of
// zero yields nothing but still honors reseed. A modulus of zero stands for
// 2^WIDTH. Unless idle or stalled, the block does one modular step a cycle
// (p + q + carry, then one compare-subtract against the modulus). A request
// first reduces the increment, then the state, mod m; each value is then a
// double-and-add over the multiplier plus the increment. req_ready is high
// only while the sequencer is idle; a finished word waits in an output register
// while the next value is computed, and a new request can be taken while the
// previous run's final word is still pending. The user must write configuration
// registers through the csr port only while idle; this is not enforced.
`timescale 1ns / 1ps

module lcg_random_generator_unit #(
   parameter int unsigned WIDTH = lcg_pkg::DefaultWidth
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_reseed,
   input  logic [lcg_pkg::CountWidth-1:0]    req_count,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [WIDTH-1:0]                  rsp_value,
   output logic                              rsp_last,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcg_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [lcg_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [lcg_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned BitCntWidth = $clog2(WIDTH);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_RED_C   = 6'b000010,
      ST_RED_X   = 6'b000100,
      ST_MUL_DBL = 6'b001000,
      ST_MUL_ADD = 6'b010000,
      ST_ADD_C   = 6'b100000
   } state_type;

   // configuration registers
   logic [WIDTH-1:0] multiplier_ff, increment_ff, modulus_ff, seed_ff;
   logic [lcg_pkg::RegIdxWidth-1:0] reg_idx;
   logic csr_write;

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] cr_ff, cr_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [BitCntWidth-1:0] cnt_ff, cnt_in;
   logic [lcg_pkg::CountWidth-1:0] rem_ff, rem_in;
   logic out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;

   // shared modular unit signals
   logic [WIDTH:0]   mod_eff;
   logic [WIDTH-1:0] op_p, op_q;
   logic             op_cin;
   logic [WIDTH:0]   unit_sum;
   logic [WIDTH+1:0] unit_diff;
   logic [WIDTH-1:0] unit_res;

   logic [lcg_pkg::CountWidth-1:0] run_len;
   logic out_free;

   // register decode
   assign reg_idx    = csr_paddr[lcg_pkg::CsrAddrWidth-1 -: lcg_pkg::RegIdxWidth];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= WIDTH'(lcg_pkg::MultiplierReset);
         increment_ff  <= WIDTH'(lcg_pkg::IncrementReset);
         modulus_ff    <= WIDTH'(lcg_pkg::ModulusReset);
         seed_ff       <= WIDTH'(lcg_pkg::SeedReset);
      end else if (csr_write) begin
         case (reg_idx)
            lcg_pkg::RegMultiplier: multiplier_ff <= csr_pwdata[WIDTH-1:0];
            lcg_pkg::RegIncrement:  increment_ff  <= csr_pwdata[WIDTH-1:0];
            lcg_pkg::RegModulus:    modulus_ff    <= csr_pwdata[WIDTH-1:0];
            lcg_pkg::RegSeed:       seed_ff       <= csr_pwdata[WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_idx)
         lcg_pkg::RegMultiplier: csr_prdata = lcg_pkg::CsrDataWidth'(multiplier_ff);
         lcg_pkg::RegIncrement:  csr_prdata = lcg_pkg::CsrDataWidth'(increment_ff);
         lcg_pkg::RegModulus:    csr_prdata = lcg_pkg::CsrDataWidth'(modulus_ff);
         lcg_pkg::RegSeed:       csr_prdata = lcg_pkg::CsrDataWidth'(seed_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // zero modulus means 2^WIDTH
   assign mod_eff = (modulus_ff == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, modulus_ff};

   // operand select for the shared unit
   always_comb begin
      op_p   = acc_ff;
      op_q   = '0;
      op_cin = 1'b0;
      case (state_ff)
         ST_RED_C, ST_RED_X: begin
            op_q   = acc_ff;
            op_cin = sh_ff[WIDTH-1];
         end
         ST_MUL_DBL: begin
            op_q = acc_ff;
         end
         ST_MUL_ADD: begin
            op_q = x_ff;
         end
         ST_ADD_C: begin
            op_q = cr_ff;
         end
         default: begin
            op_p = '0;
         end
      endcase
   end

   // shared unit: (p + q + cin) mod m, valid while p, q are below m
   assign unit_sum  = {1'b0, op_p} + {1'b0, op_q} + (WIDTH+1)'(op_cin);
   assign unit_diff = {1'b0, unit_sum} - {1'b0, mod_eff};
   assign unit_res  = unit_diff[WIDTH+1] ? unit_sum[WIDTH-1:0] : unit_diff[WIDTH-1:0];

   // run length, saturated
   assign run_len = (req_count > lcg_pkg::CountWidth'(lcg_pkg::MaxRun))
                    ? lcg_pkg::CountWidth'(lcg_pkg::MaxRun) : req_count;

   assign out_free  = ~out_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      cr_in        = cr_ff;
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_reseed) begin
                  x_in = seed_ff;
               end
               if (run_len != '0) begin
                  rem_in   = run_len;
                  acc_in   = '0;
                  sh_in    = increment_ff;
                  cnt_in   = BitCntWidth'(WIDTH - 1);
                  state_in = ST_RED_C;
               end
            end
         end
         // increment mod m, one bit a cycle from the top
         ST_RED_C: begin
            acc_in = unit_res;
            sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cr_in    = unit_res;
               acc_in   = '0;
               sh_in    = x_ff;
               cnt_in   = BitCntWidth'(WIDTH - 1);
               state_in = ST_RED_X;
            end
         end
         // state mod m
         ST_RED_X: begin
            acc_in = unit_res;
            sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               x_in     = unit_res;
               acc_in   = '0;
               sh_in    = multiplier_ff;
               cnt_in   = BitCntWidth'(WIDTH - 1);
               state_in = ST_MUL_DBL;
            end
         end
         // double-and-add over the multiplier bits
         ST_MUL_DBL, ST_MUL_ADD: begin
            acc_in = unit_res;
            if ((state_ff == ST_MUL_DBL) && sh_ff[WIDTH-1]) begin
               state_in = ST_MUL_ADD;
            end else if (cnt_ff == '0) begin
               state_in = ST_ADD_C;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               sh_in    = {sh_ff[WIDTH-2:0], 1'b0};
               state_in = ST_MUL_DBL;
            end
         end
         // add increment, hand the word to the output register once it is free
         ST_ADD_C: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = unit_res;
               out_last_in  = (rem_ff == lcg_pkg::CountWidth'(1));
               x_in         = unit_res;
               rem_in       = rem_ff - 1'b1;
               if (rem_ff == lcg_pkg::CountWidth'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  acc_in   = '0;
                  sh_in    = multiplier_ff;
                  cnt_in   = BitCntWidth'(WIDTH - 1);
                  state_in = ST_MUL_DBL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
         cnt_ff       <= '0;
         x_ff         <= WIDTH'(lcg_pkg::SeedReset);
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
         cnt_ff       <= cnt_in;
         x_ff         <= x_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      cr_ff        <= cr_in;
      sh_ff        <= sh_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ----- rtl/lcg_checker.sv -----
// port checker for the lcg random generator, bound to the top level
`timescale 1ns / 1ps
`include "lcg_random_generator_unit_assert.svh"

module lcg_checker #(
   parameter int unsigned WIDTH = lcg_pkg::DefaultWidth
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [lcg_pkg::CountWidth-1:0] req_count,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [WIDTH-1:0]               rsp_value,
   input logic                           rsp_last
);

   // a stalled word holds
   `LCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_value) && $stable(rsp_last))

   // a nonempty run keeps the block busy afterwards
   `LCG_ASSERT_NEXT(a_busy_after_req, clock, reset,
      req_valid && req_ready && (req_count != '0), !req_ready)

   // a word that is not the last means the run is still going
   `LCG_ASSERT_NOW(a_mid_run_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // no word appears right after a request is taken
   `LCG_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready,
      !$rose(rsp_valid))

endmodule

bind lcg_random_generator_unit lcg_checker #(.WIDTH(WIDTH)) u_lcg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_count (req_count),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_value (rsp_value),
   .rsp_last  (rsp_last)
);

// ----- tb/tb.sv -----
// self-checking testbench for the lcg random generator unit
`timescale 1ns / 1ps

module tb;

   localparam int unsigned Width = lcg_pkg::DefaultWidth;
   // worst request: both operand reductions plus one full value, with margin
   localparam int unsigned SettleCycles = 4 * Width + 128;
   localparam longint unsigned CycleLimit = 64'd10_000_000;
   localparam logic [Width-1:0] AllOnes = '1;

   typedef struct packed {
      logic                           reseed;
      logic [lcg_pkg::CountWidth-1:0] count;
   } gen_request_type;

   typedef struct packed {
      logic [Width-1:0] value;
      logic             last;
   } lcg_word_type;

   // block ports, inputs known from time zero
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_reseed = 1'b0;
   logic [lcg_pkg::CountWidth-1:0]   req_count = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [Width-1:0]                 rsp_value;
   logic                             rsp_last;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [lcg_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [lcg_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [lcg_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   // register index on the bus
   logic [lcg_pkg::RegIdxWidth-1:0]  csr_idx;

   // shadow registers and generator state
   logic [Width-1:0] cfg_mult;
   logic [Width-1:0] cfg_incr;
   logic [Width-1:0] cfg_mod;
   logic [Width-1:0] cfg_seed;
   logic [Width-1:0] lcg_state;

   gen_request_type pending_reqs[$];
   lcg_word_type    expected_words[$];
   logic            req_taken = 1'b0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              mismatch_count = 0;
   longint unsigned cycle_count = 0;

   int send_idle_by_phase[5] = '{0, 84, 0, 17, 0};
   int rsp_stall_by_phase[5] = '{0, 0, 84, 17, 0};

   assign csr_idx = csr_paddr[lcg_pkg::CsrAddrWidth-1:3];

   lcg_random_generator_unit #(.WIDTH(Width)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_reseed  (req_reseed),
      .req_count   (req_count),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // print one mismatch line (first hundred only) and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // one step of x <- (a*x + c) mod m, zero modulus meaning 2^width
   function automatic logic [Width-1:0] lcg_advance(input logic [Width-1:0] x);
      logic [127:0] wide;
      wide = 128'(cfg_mult) * 128'(x) + 128'(cfg_incr);
      if (cfg_mod == '0)
         return wide[Width-1:0];
      wide = wide % 128'(cfg_mod);
      return wide[Width-1:0];
   endfunction

   // expected words for one accepted request
   task automatic predict_run(input logic reseed,
                              input logic [lcg_pkg::CountWidth-1:0] count);
      int run_len;
      run_len = (count > lcg_pkg::MaxRun) ? int'(lcg_pkg::MaxRun) : int'(count);
      if (reseed)
         lcg_state = cfg_seed;
      for (int k = 0; k < run_len; k++) begin
         lcg_state = lcg_advance(lcg_state);
         expected_words.push_back('{value: lcg_state, last: (k == run_len - 1)});
      end
   endtask

   function automatic logic [Width-1:0] shadow_reg(input logic [lcg_pkg::RegIdxWidth-1:0] idx);
      case (idx)
         lcg_pkg::RegMultiplier: return cfg_mult;
         lcg_pkg::RegIncrement:  return cfg_incr;
         lcg_pkg::RegModulus:    return cfg_mod;
         default:                return cfg_seed;
      endcase
   endfunction

   // monitor: register shadow, readback check, result check, prediction
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready && !reset;
      if (reset) begin
         cfg_mult  = Width'(lcg_pkg::MultiplierReset);
         cfg_incr  = Width'(lcg_pkg::IncrementReset);
         cfg_mod   = Width'(lcg_pkg::ModulusReset);
         cfg_seed  = Width'(lcg_pkg::SeedReset);
         lcg_state = Width'(lcg_pkg::SeedReset);
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx)
               lcg_pkg::RegMultiplier: cfg_mult = csr_pwdata[Width-1:0];
               lcg_pkg::RegIncrement:  cfg_incr = csr_pwdata[Width-1:0];
               lcg_pkg::RegModulus:    cfg_mod  = csr_pwdata[Width-1:0];
               lcg_pkg::RegSeed:       cfg_seed = csr_pwdata[Width-1:0];
               default: ;
            endcase
         end
         // register readback
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            if (csr_prdata !== lcg_pkg::CsrDataWidth'(shadow_reg(csr_idx)))
               report_mismatch("register readback", csr_prdata,
                               lcg_pkg::CsrDataWidth'(shadow_reg(csr_idx)));
         end
         // result word against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with none expected", rsp_value, 0);
            end else begin
               if (rsp_value !== expected_words[0].value)
                  report_mismatch("value", rsp_value, expected_words[0].value);
               if (rsp_last !== expected_words[0].last)
                  report_mismatch("last", rsp_last, expected_words[0].last);
               void'(expected_words.pop_front());
            end
         end
         // accepted request
         if (req_valid && req_ready)
            predict_run(req_reseed, req_count);
      end
   end

   // request driver fed from the pending queue
   always @(negedge clock) begin
      gen_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_valid  <= 1'b1;
            req_reseed <= next_req.reseed;
            req_count  <= next_req.count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one apb transfer: setup cycle then access cycle
   task automatic csr_access(input logic write, input logic [lcg_pkg::RegIdxWidth-1:0] idx,
                             input logic [Width-1:0] data);
      logic [lcg_pkg::CsrDataWidth-1:0] bus_word;
      // junk in the upper bits must be dropped by the register
      bus_word = {$urandom, $urandom};
      bus_word[Width-1:0] = data;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= bus_word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_reg(input logic [lcg_pkg::RegIdxWidth-1:0] idx,
                          input logic [Width-1:0] data);
      csr_access(1'b1, idx, data);
      csr_access(1'b0, idx, '0);
   endtask

   task automatic queue_request(input logic reseed, input int count);
      pending_reqs.push_back('{reseed: reseed, count: lcg_pkg::CountWidth'(count)});
   endtask

   // wait until every request is taken and every word is back, then let the block settle
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register value biased toward zero, all ones and small numbers
   function automatic logic [Width-1:0] rand_word();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return '0;
         1: return AllOnes;
         2: return Width'($urandom_range(15));
         default: return r[Width-1:0];
      endcase
   endfunction

   // mostly short runs, some zero or long ones, some above the saturation point
   function automatic int rand_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return $urandom_range(8, 1);
      else if (pick < 78)
         return 0;
      else if (pick < 86)
         return $urandom_range(20, 9);
      else
         return $urandom_range(127, 21);
   endfunction

   // stimulus
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers and of the state
      csr_access(1'b0, lcg_pkg::RegMultiplier, '0);
      csr_access(1'b0, lcg_pkg::RegIncrement, '0);
      csr_access(1'b0, lcg_pkg::RegModulus, '0);
      csr_access(1'b0, lcg_pkg::RegSeed, '0);
      queue_request(1'b0, 1);
      queue_request(1'b0, 0);
      queue_request(1'b1, 0);
      queue_request(1'b0, 2);
      queue_request(1'b1, 64);
      queue_request(1'b0, 65);
      queue_request(1'b0, 127);
      queue_request(1'b1, 1);
      wait_drained();

      // zero modulus means plain truncation, all operands at their maximum
      set_reg(lcg_pkg::RegMultiplier, AllOnes);
      set_reg(lcg_pkg::RegIncrement, AllOnes);
      set_reg(lcg_pkg::RegModulus, '0);
      set_reg(lcg_pkg::RegSeed, AllOnes);
      queue_request(1'b1, 3);
      queue_request(1'b0, 1);
      wait_drained();

      // modulus one, state far above it
      set_reg(lcg_pkg::RegModulus, Width'(1));
      queue_request(1'b0, 2);
      queue_request(1'b1, 1);
      wait_drained();

      // zero multiplier, largest modulus, increment equal to it
      set_reg(lcg_pkg::RegMultiplier, '0);
      set_reg(lcg_pkg::RegModulus, AllOnes);
      set_reg(lcg_pkg::RegSeed, '0);
      queue_request(1'b1, 2);
      wait_drained();

      // seed above a small modulus, top multiplier bit set
      set_reg(lcg_pkg::RegMultiplier, {1'b1, {(Width-2){1'b0}}, 1'b1});
      set_reg(lcg_pkg::RegIncrement, '0);
      set_reg(lcg_pkg::RegModulus, Width'(7));
      set_reg(lcg_pkg::RegSeed, AllOnes);
      queue_request(1'b1, 4);
      queue_request(1'b0, 3);
      wait_drained();

      // modulus changed between requests without reseeding
      set_reg(lcg_pkg::RegModulus, AllOnes - Width'(58));
      queue_request(1'b0, 2);
      wait_drained();
      set_reg(lcg_pkg::RegModulus, Width'(3));
      queue_request(1'b0, 2);
      wait_drained();

      // wraparound near the largest modulus
      set_reg(lcg_pkg::RegMultiplier, Width'(1));
      set_reg(lcg_pkg::RegIncrement, Width'(1));
      set_reg(lcg_pkg::RegModulus, AllOnes);
      set_reg(lcg_pkg::RegSeed, AllOnes - Width'(1));
      queue_request(1'b1, 3);
      wait_drained();

      // random phases, each with its own settings and idling
      for (int phase = 0; phase < 5; phase++) begin
         set_reg(lcg_pkg::RegMultiplier, rand_word());
         set_reg(lcg_pkg::RegIncrement, rand_word());
         set_reg(lcg_pkg::RegModulus, rand_word());
         set_reg(lcg_pkg::RegSeed, rand_word());
         send_idle_pct = send_idle_by_phase[phase];
         rsp_stall_pct = rsp_stall_by_phase[phase];
         for (int k = 0; k < 44; k++)
            queue_request($urandom_range(99) < 20, rand_count());
         wait_drained();
      end

      if (expected_words.size() != 0)
         report_mismatch("words never received", 0, expected_words.size());
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- lcg_random_generator_unit.f -----
+incdir+rtl
rtl/lcg_pkg.sv
rtl/lcg_random_generator_unit.sv
rtl/lcg_checker.sv
tb/tb.sv
